[rtl/core/asl_pkg.sv]
package asl_pkg;

    // Field widths
    localparam int ANGLE_IN_W = 24;
    localparam int TIME_W     = 20;
    localparam int RATE_W     = 20;
    localparam int THR_W      = 10;
    localparam int OUT_W      = 19;
    localparam int CFG_DATA_W = 20;

    localparam int ASL_FRAC_BITS = 8;

    localparam int RATE_RESET   = 23040;
    localparam int THRESH_RESET = 125;

    // Whole-degree part of the turn wrap
    localparam int TURN_DEG        = 360;
    localparam int DEG_W           = 9;
    localparam int TURN_MOD_W      = 10;
    localparam int DEG_RECIP       = 11930464;  // floor(2^32 / 360)
    localparam int DEG_RECIP_SHIFT = 32;

    // Step: (elapsed * rate) / 10^6 = ((elapsed * rate) >> 6) / 15625
    localparam int STEP_PROD_W    = TIME_W + RATE_W;
    localparam int US_SHIFT       = 6;
    localparam int US_ODD         = 15625;
    localparam int US_RECIP       = 1099511;    // floor(2^34 / 15625)
    localparam int US_RECIP_W     = 21;
    localparam int US_RECIP_SHIFT = 34;
    localparam int STEP_T_W       = STEP_PROD_W - US_SHIFT;
    localparam int STEP_LO_W      = 17;
    localparam int STEP_HI_W      = STEP_T_W - STEP_LO_W;
    localparam int STEP_PP_W      = STEP_LO_W + US_RECIP_W;
    localparam int STEP_SUM_W     = STEP_T_W + US_RECIP_W;
    localparam int STEP_W         = 21;
    localparam int STEP_CHK_W     = 35;

    typedef enum logic
    {
        CFG_RATE   = 1'b0,
        CFG_THRESH = 1'b1
    } asl_cfg_idx_t;

    // Per-stage load strobes
    typedef struct packed
    {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } asl_load_t;

endpackage

[rtl/core/asl_wrap.sv]
module asl_wrap
    import asl_pkg::*;
#(
    parameter int FRAC_BITS = ASL_FRAC_BITS
)
(
    input  logic                         clk,
    input  asl_load_t                    load,
    input  logic signed [ANGLE_IN_W-1:0] angle,
    output logic [FRAC_BITS+DEG_W-1:0]   wrapped
);

    localparam int HW  = ANGLE_IN_W - FRAC_BITS;
    localparam int QW  = HW - 7;
    localparam int PW  = HW + 25;
    localparam int OFS = (1 << (HW - 1)) % TURN_DEG;

    logic [HW-1:0]         hu;
    logic [PW-1:0]         prod;

    logic [HW-1:0]         hu1_reg, hu1_next;
    logic [QW-1:0]         q1_reg, q1_next;
    logic [FRAC_BITS-1:0]  lo1_reg, lo1_next;
    logic [TURN_MOD_W-1:0] r2_reg, r2_next;
    logic [FRAC_BITS-1:0]  lo2_reg, lo2_next;
    logic [DEG_W-1:0]      r_fold;
    logic [DEG_W-1:0]      r_deg;
    logic [FRAC_BITS+DEG_W-1:0] wrapped_reg, wrapped_next;

    // Whole degrees biased to unsigned; the bias is taken back out in stage 3
    assign hu   = {~angle[ANGLE_IN_W-1], angle[ANGLE_IN_W-2:FRAC_BITS]};
    assign prod = PW'(hu) * PW'(DEG_RECIP);

    always_comb
    begin
        hu1_next = hu;
        q1_next  = prod[DEG_RECIP_SHIFT +: QW];
        lo1_next = angle[FRAC_BITS-1:0];
    end

    // Quotient estimate may be one low, so the remainder lies in [0, 720)
    always_comb
    begin
        r2_next  = TURN_MOD_W'(hu1_reg) - TURN_MOD_W'(q1_reg * TURN_DEG);
        lo2_next = lo1_reg;
    end

    always_comb
    begin
        if (r2_reg >= TURN_MOD_W'(TURN_DEG))
        begin
            r_fold = DEG_W'(r2_reg - TURN_MOD_W'(TURN_DEG));
        end
        else
        begin
            r_fold = DEG_W'(r2_reg);
        end
        if (r_fold >= DEG_W'(OFS))
        begin
            r_deg = r_fold - DEG_W'(OFS);
        end
        else
        begin
            r_deg = r_fold + DEG_W'(TURN_DEG - OFS);
        end
        wrapped_next = {r_deg, lo2_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            hu1_reg <= hu1_next;
            q1_reg  <= q1_next;
            lo1_reg <= lo1_next;
        end
        if (load.s2)
        begin
            r2_reg  <= r2_next;
            lo2_reg <= lo2_next;
        end
        if (load.s3)
        begin
            wrapped_reg <= wrapped_next;
        end
    end

    assign wrapped = wrapped_reg;

endmodule

[rtl/core/asl_step.sv]
module asl_step
    import asl_pkg::*;
(
    input  logic              clk,
    input  asl_load_t         load,
    input  logic [TIME_W-1:0] elapsed_us,
    input  logic [RATE_W-1:0] rate,
    output logic [STEP_W-1:0] step
);

    logic [STEP_PROD_W-1:0] p1_reg, p1_next;
    logic [STEP_T_W-1:0]    t_cur;
    logic [STEP_T_W-1:0]    t2_reg, t2_next;
    logic [STEP_PP_W-1:0]   pph2_reg, pph2_next;
    logic [STEP_PP_W-1:0]   ppl2_reg, ppl2_next;
    logic [STEP_SUM_W-1:0]  sum;
    logic [STEP_T_W-1:0]    t3_reg, t3_next;
    logic [STEP_W-1:0]      q3_reg, q3_next;
    logic [STEP_CHK_W-1:0]  bound;
    logic [STEP_W-1:0]      step_reg, step_next;

    assign p1_next = STEP_PROD_W'(elapsed_us) * STEP_PROD_W'(rate);

    // Reciprocal multiply split in two partial products
    always_comb
    begin
        t_cur     = p1_reg[STEP_PROD_W-1:US_SHIFT];
        t2_next   = t_cur;
        pph2_next = STEP_PP_W'(t_cur[STEP_T_W-1:STEP_LO_W]) * STEP_PP_W'(US_RECIP);
        ppl2_next = STEP_PP_W'(t_cur[STEP_LO_W-1:0]) * STEP_PP_W'(US_RECIP);
    end

    always_comb
    begin
        sum     = (STEP_SUM_W'(pph2_reg) << STEP_LO_W) + STEP_SUM_W'(ppl2_reg);
        q3_next = sum[US_RECIP_SHIFT +: STEP_W];
        t3_next = t2_reg;
    end

    // Estimate is exact or one low
    always_comb
    begin
        bound = STEP_CHK_W'(q3_reg) * STEP_CHK_W'(US_ODD) + STEP_CHK_W'(US_ODD);
        if (STEP_CHK_W'(t3_reg) >= bound)
        begin
            step_next = q3_reg + STEP_W'(1);
        end
        else
        begin
            step_next = q3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.s1)
        begin
            p1_reg <= p1_next;
        end
        if (load.s2)
        begin
            t2_reg   <= t2_next;
            pph2_reg <= pph2_next;
            ppl2_reg <= ppl2_next;
        end
        if (load.s3)
        begin
            t3_reg <= t3_next;
            q3_reg <= q3_next;
        end
        if (load.s4)
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

[rtl/core/asl_slew.sv]
module asl_slew
    import asl_pkg::*;
#(
    parameter int FRAC_BITS = ASL_FRAC_BITS
)
(
    input  logic                       clk,
    input  asl_load_t                  load,
    input  logic [FRAC_BITS+DEG_W-1:0] cur_wrapped,
    input  logic [FRAC_BITS+DEG_W-1:0] tgt_wrapped,
    input  logic [STEP_W-1:0]          step,
    input  logic [THR_W-1:0]           thresh,
    output logic signed [OUT_W-1:0]    new_angle,
    output logic                       reached
);

    localparam int AW = FRAC_BITS + DEG_W;
    localparam int RW = AW + 2;
    localparam int CW = ((RW > STEP_W) ? RW : STEP_W) + 1;
    localparam int FT = TURN_DEG << FRAC_BITS;
    localparam logic signed [RW-1:0] FT_S   = RW'(FT);
    localparam logic signed [RW-1:0] HALF_S = RW'(FT / 2);

    logic [AW-1:0]        cur4_reg, cur4_next;
    logic [AW-1:0]        tgt4_reg, tgt4_next;
    logic signed [AW:0]   d4_reg, d4_next;

    logic signed [RW-1:0] cur_s, tgt_s, d_s, ad, goal, span, stp, res;
    logic                 far_up, far_dn, hit, step_ge, up;

    logic signed [OUT_W-1:0] new_angle_reg, new_angle_next;
    logic                    reached_reg, reached_next;

    always_comb
    begin
        cur4_next = cur_wrapped;
        tgt4_next = tgt_wrapped;
        d4_next   = signed'({1'b0, tgt_wrapped}) - signed'({1'b0, cur_wrapped});
    end

    always_comb
    begin
        cur_s  = signed'(RW'(cur4_reg));
        tgt_s  = signed'(RW'(tgt4_reg));
        d_s    = RW'(d4_reg);
        ad     = (d_s < 0) ? -d_s : d_s;
        // Target a turn below or above is nearer only when strictly so
        far_up = d_s > HALF_S;
        far_dn = d_s < -HALF_S;
        if (far_up)
        begin
            goal = tgt_s - FT_S;
            span = FT_S - d_s;
        end
        else if (far_dn)
        begin
            goal = tgt_s + FT_S;
            span = FT_S + d_s;
        end
        else
        begin
            goal = tgt_s;
            span = ad;
        end
        hit     = ad < signed'(RW'(thresh));
        step_ge = CW'(step) >= CW'($unsigned(span));
        up      = far_dn || (!far_up && (d_s > 0));
        // Only used when step is below span, so the truncation is safe
        stp     = signed'(RW'(step));
        if (hit || step_ge)
        begin
            res = goal;
        end
        else if (up)
        begin
            res = cur_s + stp;
        end
        else
        begin
            res = cur_s - stp;
        end
        new_angle_next = OUT_W'(res);
        reached_next   = hit;
    end

    always_ff @(posedge clk)
    begin
        if (load.s4)
        begin
            cur4_reg <= cur4_next;
            tgt4_reg <= tgt4_next;
            d4_reg   <= d4_next;
        end
        if (load.s5)
        begin
            new_angle_reg <= new_angle_next;
            reached_reg   <= reached_next;
        end
    end

    assign new_angle = new_angle_reg;
    assign reached   = reached_reg;

endmodule

[rtl/core/angle_slew_toward_target.sv]
// A word accepted at the input passes through six registers before it shows on the output.
// Throughput: one word per cycle; each stage holds only while the stage after it is full
// and stalled, so the input stays ready whenever any stage is empty.
// The critical stages are the reciprocal multiplies for the turn wrap and the step divide.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the rate and snap
// threshold defaults; data registers are not reset.
module angle_slew_toward_target
    import asl_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ASL_FRAC_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ANGLE_IN_W-1:0] current_angle,
    input  logic signed [ANGLE_IN_W-1:0] target_angle,
    input  logic [TIME_W-1:0]            elapsed_us,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_W-1:0]      new_angle,
    output logic                         reached,
    input  logic                         cfg_wen,
    input  asl_cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int NSTAGE = 6;
    localparam int AW     = ANGLE_FRAC_BITS + DEG_W;

    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE-1:0] ld;
    asl_load_t         load;

    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [THR_W-1:0]  thresh_reg, thresh_next;

    logic signed [ANGLE_IN_W-1:0] cur0_reg, tgt0_reg;
    logic [TIME_W-1:0]            el0_reg;

    logic [AW-1:0]     cur_wrapped, tgt_wrapped;
    logic [STEP_W-1:0] step;

    // A stage loads when empty or when the one after it moves on
    always_comb
    begin
        ld[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next[0] = ld[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_comb
    begin
        load.s1 = ld[1];
        load.s2 = ld[2];
        load.s3 = ld[3];
        load.s4 = ld[4];
        load.s5 = ld[5];
    end

    always_comb
    begin
        rate_next   = rate_reg;
        thresh_next = thresh_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_RATE:   rate_next   = cfg_data[RATE_W-1:0];
                CFG_THRESH: thresh_next = cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rate_reg   <= RATE_W'(RATE_RESET);
            thresh_reg <= THR_W'(THRESH_RESET);
        end
        else
        begin
            valid_reg  <= valid_next;
            rate_reg   <= rate_next;
            thresh_reg <= thresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            cur0_reg <= current_angle;
            tgt0_reg <= target_angle;
            el0_reg  <= elapsed_us;
        end
    end

    asl_wrap #(
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_wrap_cur (
        .clk     (clk),
        .load    (load),
        .angle   (cur0_reg),
        .wrapped (cur_wrapped)
    );

    asl_wrap #(
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_wrap_tgt (
        .clk     (clk),
        .load    (load),
        .angle   (tgt0_reg),
        .wrapped (tgt_wrapped)
    );

    asl_step u_step (
        .clk        (clk),
        .load       (load),
        .elapsed_us (el0_reg),
        .rate       (rate_reg),
        .step       (step)
    );

    asl_slew #(
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_slew (
        .clk         (clk),
        .load        (load),
        .cur_wrapped (cur_wrapped),
        .tgt_wrapped (tgt_wrapped),
        .step        (step),
        .thresh      (thresh_reg),
        .new_angle   (new_angle),
        .reached     (reached)
    );

    assign in_ready  = ld[0];
    assign out_valid = valid_reg[NSTAGE-1];

`ifndef SYNTHESIS
    // Any empty stage means the input side can take a word
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg != {NSTAGE{1'b1}}) |-> in_ready)
        else $error("input stalled with room in pipeline");

    // A word in the last compute stage reaches the output when the output moves
    a_word_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-2] && ld[NSTAGE-1]) |=> out_valid)
        else $error("word lost before output");

    // Output drained with nothing behind it leaves the output empty
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !valid_reg[NSTAGE-2]) |=> !out_valid)
        else $error("output word invented");
`endif

endmodule
